FILE: design/vtce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_pkg
// shared types and constants for the vector terminal coordinate encoder
// ----------------------------------------------------------------------------
package vtce_pkg;

    localparam int FIELD_W = 12;   // raw coordinate width, signed
    localparam int COORD_W = 10;   // clamped coordinate width, 0..1023
    localparam int PART_W  = 5;    // high and low address parts
    localparam int BYTE_W  = 8;

    // command codes
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_FORGET = 1'b1;

    // byte codes
    localparam logic [BYTE_W-1:0] SEP_BYTE = 8'd29;
    localparam logic [2:0] HIGH_TAG  = 3'b001;  // 32 + part
    localparam logic [2:0] LOW_Y_TAG = 3'b011;  // 96 + part
    localparam logic [2:0] LOW_X_TAG = 3'b010;  // 64 + part

    // one queued segment, coordinates already clamped
    typedef struct packed {
        logic               sep;
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
    } seg_entry_t;

    // back end sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEP,
        PH_FROM,
        PH_TO
    } phase_t;

endpackage

FILE: design/vtce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_front
// accepts segment beats, tracks the pen and classifies each draw
// ----------------------------------------------------------------------------
module vtce_front
    import vtce_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      seg_valid,
    output logic                      seg_ready,
    input  logic                      command,
    input  logic signed [FIELD_W-1:0] from_x,
    input  logic signed [FIELD_W-1:0] from_y,
    input  logic signed [FIELD_W-1:0] to_x,
    input  logic signed [FIELD_W-1:0] to_y,
    output logic                      push,
    output seg_entry_t                push_entry,
    input  logic                      queue_full
);

    logic [FIELD_W-1:0] pen_x_reg, pen_x_next;
    logic [FIELD_W-1:0] pen_y_reg, pen_y_next;
    logic               pen_known_reg, pen_known_next;
    logic               accept;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [FIELD_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v[FIELD_W-1])
            r = '0;
        else if (|v[FIELD_W-2:COORD_W])
            r = '1;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    assign seg_ready = !queue_full;
    assign accept    = seg_valid && seg_ready;

    always_comb
    begin
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        pen_known_next = pen_known_reg;
        push           = 1'b0;

        push_entry.sep    = !pen_known_reg || (pen_x_reg != from_x) || (pen_y_reg != from_y);
        push_entry.from_x = clamp_coord(from_x);
        push_entry.from_y = clamp_coord(from_y);
        push_entry.to_x   = clamp_coord(to_x);
        push_entry.to_y   = clamp_coord(to_y);

        if (accept)
        begin
            if (command == CMD_FORGET)
            begin
                pen_known_next = 1'b0;
            end
            else
            begin
                push           = 1'b1;
                pen_x_next     = to_x;
                pen_y_next     = to_y;
                pen_known_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            pen_known_reg <= 1'b0;
        end
        else
        begin
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            pen_known_reg <= pen_known_next;
        end
    end

endmodule

FILE: design/vtce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_queue
// short segment queue between front and back
// ----------------------------------------------------------------------------
module vtce_queue
    import vtce_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  seg_entry_t push_entry,
    input  logic       pop,
    output seg_entry_t head_entry,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seg_entry_t         slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/vtce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_back
// byte sequencer: separator, start point, end point, one byte per unstalled cycle
// ----------------------------------------------------------------------------
module vtce_back
    import vtce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  seg_entry_t        head_entry,
    input  logic              queue_empty,
    output logic              pop,
    output logic              byte_valid,
    input  logic              byte_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last
);

    phase_t             phase_reg, phase_next;
    seg_entry_t         cur_reg, cur_next;
    logic [3:0]         mask_reg, mask_next;    // bytes still to send: hy, ly, hx, lx
    logic               live_reg, live_next;    // mask_reg holds the current point
    logic [PART_W-1:0]  prev_hy_reg, prev_hy_next;
    logic [PART_W-1:0]  prev_ly_reg, prev_ly_next;
    logic [PART_W-1:0]  prev_hx_reg, prev_hx_next;
    logic               bytes_known_reg, bytes_known_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               last_reg, last_next;

    logic               slot_free;
    logic               emit;
    logic               load;
    logic [COORD_W-1:0] pt_x;
    logic [COORD_W-1:0] pt_y;
    logic [PART_W-1:0]  hy, ly, hx, lx;
    logic [3:0]         fresh;
    logic [3:0]         mask_eff;
    logic [3:0]         pick;
    logic [3:0]         rem;

    assign slot_free  = !out_valid_reg || byte_ready;
    assign emit       = (phase_reg != PH_IDLE) && slot_free;

    assign byte_valid = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = last_reg;

    always_comb
    begin
        pt_x = (phase_reg == PH_FROM) ? cur_reg.from_x : cur_reg.to_x;
        pt_y = (phase_reg == PH_FROM) ? cur_reg.from_y : cur_reg.to_y;
        hy   = pt_y[COORD_W-1:PART_W];
        ly   = pt_y[PART_W-1:0];
        hx   = pt_x[COORD_W-1:PART_W];
        lx   = pt_x[PART_W-1:0];

        fresh[0] = !bytes_known_reg || (hy != prev_hy_reg);
        fresh[2] = !bytes_known_reg || (hx != prev_hx_reg);
        fresh[1] = !bytes_known_reg || (ly != prev_ly_reg) || fresh[2];
        fresh[3] = 1'b1;

        mask_eff = live_reg ? mask_reg : fresh;
        pick     = mask_eff & (~mask_eff + 4'd1);
        rem      = mask_eff & ~pick;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        cur_next         = cur_reg;
        mask_next        = mask_reg;
        live_next        = live_reg;
        prev_hy_next     = prev_hy_reg;
        prev_ly_next     = prev_ly_reg;
        prev_hx_next     = prev_hx_reg;
        bytes_known_next = bytes_known_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        last_next        = last_reg;
        load             = (phase_reg == PH_IDLE);

        if (slot_free)
            out_valid_next = emit;

        if (emit)
        begin
            last_next = 1'b0;
            unique case (phase_reg)
                PH_SEP:
                begin
                    out_byte_next    = SEP_BYTE;
                    bytes_known_next = 1'b0;
                    live_next        = 1'b0;
                    phase_next       = PH_FROM;
                end
                PH_FROM, PH_TO:
                begin
                    if (pick[0])
                    begin
                        out_byte_next = {HIGH_TAG, hy};
                        prev_hy_next  = hy;
                    end
                    else if (pick[1])
                    begin
                        out_byte_next = {LOW_Y_TAG, ly};
                        prev_ly_next  = ly;
                    end
                    else if (pick[2])
                    begin
                        out_byte_next = {HIGH_TAG, hx};
                        prev_hx_next  = hx;
                    end
                    else
                    begin
                        out_byte_next = {LOW_X_TAG, lx};
                    end

                    if (rem == 4'd0)
                    begin
                        bytes_known_next = 1'b1;
                        live_next        = 1'b0;
                        if (phase_reg == PH_FROM)
                        begin
                            phase_next = PH_TO;
                        end
                        else
                        begin
                            last_next  = 1'b1;
                            phase_next = PH_IDLE;
                            load       = 1'b1;
                        end
                    end
                    else
                    begin
                        mask_next = rem;
                        live_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        pop = load && !queue_empty;
        if (pop)
        begin
            cur_next   = head_entry;
            live_next  = 1'b0;
            phase_next = head_entry.sep ? PH_SEP : PH_TO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            live_reg        <= 1'b0;
            mask_reg        <= '0;
            prev_hy_reg     <= '0;
            prev_ly_reg     <= '0;
            prev_hx_reg     <= '0;
            bytes_known_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            live_reg        <= live_next;
            mask_reg        <= mask_next;
            prev_hy_reg     <= prev_hy_next;
            prev_ly_reg     <= prev_ly_next;
            prev_hx_reg     <= prev_hx_next;
            bytes_known_reg <= bytes_known_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

endmodule

FILE: design/vector_terminal_coordinate_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_terminal_coordinate_encoder
// turns line segments into a vector terminal address byte stream
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  segment  | seg_valid / seg_ready | command, from_x, from_y, to_x, to_y
//  byte     | byte_valid/byte_ready | out_byte, last
//
//  a draw segment gives 1 to 9 byte beats from the back end sequencer, one per
//  cycle while byte_ready is high; separator, start point, end point set its length
//  a forget beat is taken and gives no byte
//  segments are taken back to back while the queue has room, even while a
//  finished byte waits in the output register
//  rst_n clears the pen, the address byte memory, the queue and the output
// ----------------------------------------------------------------------------
module vector_terminal_coordinate_encoder
    import vtce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // segment channel
    input  logic                      seg_valid,
    output logic                      seg_ready,
    input  logic                      command,
    input  logic signed [FIELD_W-1:0] from_x,
    input  logic signed [FIELD_W-1:0] from_y,
    input  logic signed [FIELD_W-1:0] to_x,
    input  logic signed [FIELD_W-1:0] to_y,
    // byte channel
    output logic                      byte_valid,
    input  logic                      byte_ready,
    output logic [BYTE_W-1:0]         out_byte,
    output logic                      last
);

    // front to queue
    logic       push;
    seg_entry_t push_entry;
    logic       queue_full;

    // queue to back
    logic       pop;
    seg_entry_t head_entry;
    logic       queue_empty;

    // front: pen tracking against the raw coordinates, clamping, separator decision
    vtce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .command    (command),
        .from_x     (from_x),
        .from_y     (from_y),
        .to_x       (to_x),
        .to_y       (to_y),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    // decouples segment acceptance from byte output stalls
    vtce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    // back: address byte memory and the byte sequencer with its output register
    vtce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_entry  (head_entry),
        .queue_empty (queue_empty),
        .pop         (pop),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

endmodule

FILE: tb/vtce_byte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_byte_checker
// watches the segment and byte channels of the coordinate encoder, works out
// the terminal bytes each segment must give and compares them beat by beat
// ----------------------------------------------------------------------------
module vtce_byte_checker
    import vtce_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      seg_valid,
    input  logic                      seg_ready,
    input  logic                      command,
    input  logic signed [FIELD_W-1:0] from_x,
    input  logic signed [FIELD_W-1:0] from_y,
    input  logic signed [FIELD_W-1:0] to_x,
    input  logic signed [FIELD_W-1:0] to_y,
    input  logic                      byte_valid,
    input  logic                      byte_ready,
    input  logic [BYTE_W-1:0]         out_byte,
    input  logic                      last,
    output int                        fail_count,
    output int                        pending
);

    localparam int COORD_TOP = 1023;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              is_last;
    } term_byte_t;

    term_byte_t bytes_due[$];

    // pen and the address parts the terminal holds
    logic [FIELD_W-1:0] pen_at_x;
    logic [FIELD_W-1:0] pen_at_y;
    logic               pen_valid;
    logic [PART_W-1:0]  held_hy;
    logic [PART_W-1:0]  held_ly;
    logic [PART_W-1:0]  held_hx;
    logic               held_valid;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [FIELD_W-1:0] v);
        if (v < 0)
            return '0;
        if (v > COORD_TOP)
            return COORD_TOP[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        bytes_due.push_back('{value: b, is_last: 1'b0});
    endfunction

    function automatic void encode_point(input logic signed [FIELD_W-1:0] xr,
                                         input logic signed [FIELD_W-1:0] yr);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic hy_new;
        logic ly_new;
        logic hx_new;
        x = clamp_coord(xr);
        y = clamp_coord(yr);
        hy_new = !held_valid || (y[9:5] != held_hy);
        ly_new = !held_valid || (y[4:0] != held_ly);
        hx_new = !held_valid || (x[9:5] != held_hx);
        if (hy_new)
        begin
            push_byte({HIGH_TAG, y[9:5]});
            held_hy = y[9:5];
        end
        // low y also goes out when only high x moved
        if (ly_new || hx_new)
        begin
            push_byte({LOW_Y_TAG, y[4:0]});
            held_ly = y[4:0];
            if (hx_new)
            begin
                push_byte({HIGH_TAG, x[9:5]});
                held_hx = x[9:5];
            end
        end
        push_byte({LOW_X_TAG, x[4:0]});
        held_valid = 1'b1;
    endfunction

    function automatic void encode_segment();
        // raw 12-bit compare, before clamping
        if (!pen_valid || pen_at_x != from_x || pen_at_y != from_y)
        begin
            push_byte(SEP_BYTE);
            held_valid = 1'b0;
            encode_point(from_x, from_y);
        end
        encode_point(to_x, to_y);
        pen_at_x  = to_x;
        pen_at_y  = to_y;
        pen_valid = 1'b1;
        bytes_due[bytes_due.size()-1].is_last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        term_byte_t want;
        if (!rst_n)
        begin
            bytes_due.delete();
            pen_at_x   = '0;
            pen_at_y   = '0;
            pen_valid  = 1'b0;
            held_hy    = '0;
            held_ly    = '0;
            held_hx    = '0;
            held_valid = 1'b0;
            pending    = 0;
        end
        else
        begin
            // a byte beat always belongs to an earlier segment, so check first
            if (byte_valid && byte_ready)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("out_byte: no byte expected, got %0d (last %0d)", out_byte, last);
                    fail_count++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (out_byte !== want.value)
                    begin
                        $error("out_byte: expected %0d, got %0d", want.value, out_byte);
                        fail_count++;
                    end
                    if (last !== want.is_last)
                    begin
                        $error("last: expected %0d, got %0d", want.is_last, last);
                        fail_count++;
                    end
                end
            end
            if (seg_valid && seg_ready)
            begin
                if (command == CMD_FORGET)
                    pen_valid = 1'b0;
                else
                    encode_segment();
            end
            pending = bytes_due.size();
        end
    end

endmodule

FILE: tb/tb_vector_terminal_coordinate_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_terminal_coordinate_encoder
// drives line segments and forget beats into the coordinate encoder, directed
// corner cases first, then random polylines with breaks and noise; the byte
// checker beside the block predicts and compares every byte beat
// ----------------------------------------------------------------------------
module tb_vector_terminal_coordinate_encoder;
    import vtce_pkg::*;

    localparam int RANDOM_ITEMS  = 110;
    // longest quiet spell in a good run is the long receiver hold-off
    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD     = 200;
    localparam int HOLD_AFTER    = 40;
    // queue of two segments plus the output register, nine bytes at most each
    localparam int DRAIN_CYCLES  = 32;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      seg_valid  = 1'b0;
    logic                      seg_ready;
    logic                      command    = CMD_DRAW;
    logic signed [FIELD_W-1:0] from_x     = '0;
    logic signed [FIELD_W-1:0] from_y     = '0;
    logic signed [FIELD_W-1:0] to_x       = '0;
    logic signed [FIELD_W-1:0] to_y       = '0;
    logic                      byte_valid;
    logic                      byte_ready = 1'b0;
    logic [BYTE_W-1:0]         out_byte;
    logic                      last;

    int fail_count;
    int pending;

    // sender side bookkeeping
    int                 segs_taken = 0;
    int                 burst_left = 0;
    logic [FIELD_W-1:0] chain_x    = '0;
    logic [FIELD_W-1:0] chain_y    = '0;

    // receiver pattern
    rx_mode_t rx_mode   = RX_STEADY;
    int       mode_left = 0;
    int       rx_tick   = 0;
    bit       hold_done = 1'b0;

    int quiet_cycles = 0;

    vector_terminal_coordinate_encoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .command    (command),
        .from_x     (from_x),
        .from_y     (from_y),
        .to_x       (to_x),
        .to_y       (to_y),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .out_byte   (out_byte),
        .last       (last)
    );

    vtce_byte_checker u_byte_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .command    (command),
        .from_x     (from_x),
        .from_y     (from_y),
        .to_x       (to_x),
        .to_y       (to_y),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .out_byte   (out_byte),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // sender helpers
    // ------------------------------------------------------------------------

    // offer one segment beat and hold it until taken; draw beats move the chain
    task automatic offer(input logic c, input int fx, input int fy, input int tx,
                         input int ty);
        seg_valid <= 1'b1;
        command   <= c;
        from_x    <= FIELD_W'(fx);
        from_y    <= FIELD_W'(fy);
        to_x      <= FIELD_W'(tx);
        to_y      <= FIELD_W'(ty);
        @(posedge clk);
        while (!seg_ready)
            @(posedge clk);
        if (c == CMD_DRAW)
        begin
            chain_x = FIELD_W'(tx);
            chain_y = FIELD_W'(ty);
        end
    endtask

    // bursts of random length, then a random gap; a zero gap keeps valid high
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                seg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // a coordinate anywhere in the 12-bit range, biased to the drawable area
    function automatic int pick_coord();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return $urandom_range(1023, 0);
        if (r < 80)
            return $urandom();
        case ($urandom_range(5, 0))
            0: return -2048;
            1: return -1;
            2: return 0;
            3: return 1023;
            4: return 1024;
            default: return 2047;
        endcase
    endfunction

    // a point near the end of the current chain, often sharing address parts
    function automatic int nudge(input logic [FIELD_W-1:0] v);
        int d;
        d = $urandom_range(80, 0) - 40;
        return int'(v) + d;
    endfunction

    task automatic offer_random();
        int r;
        int s;
        int tx;
        int ty;
        r = $urandom_range(99, 0);
        s = $urandom_range(9, 0);
        if (s < 4)
        begin
            tx = nudge(chain_x);
            ty = nudge(chain_y);
        end
        else if (s < 5)
        begin
            tx = int'(chain_x);
            ty = int'(chain_y);
        end
        else
        begin
            tx = pick_coord();
            ty = pick_coord();
        end
        if (r < 8)
            offer(CMD_FORGET, $urandom(), $urandom(), $urandom(), $urandom());
        else if (r < 72)
            // well-formed continuation of the polyline
            offer(CMD_DRAW, int'(chain_x), int'(chain_y), tx, ty);
        else if (r < 86)
            // broken chain: fresh start point
            offer(CMD_DRAW, pick_coord(), pick_coord(), tx, ty);
        else
            offer(CMD_DRAW, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // ------------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pen unknown after reset: separator and full start address
        offer(CMD_DRAW, 0, 0, 1023, 1023);            pace();
        // same point again: only the low x byte
        offer(CMD_DRAW, 1023, 1023, 1023, 1023);      pace();
        // low x moves only
        offer(CMD_DRAW, 1023, 1023, 1000, 1023);      pace();
        // low y moves
        offer(CMD_DRAW, 1000, 1023, 1000, 1000);      pace();
        // high x moves, drags low y along
        offer(CMD_DRAW, 1000, 1000, 0, 1000);         pace();
        // high and low y move
        offer(CMD_DRAW, 0, 1000, 0, 0);               pace();
        // high y alone
        offer(CMD_DRAW, 0, 0, 31, 32);                pace();
        // end point outside the screen, clamps to the corner
        offer(CMD_DRAW, 31, 32, -2048, 2047);         pace();
        // start clamps like the pen but differs raw: separator
        offer(CMD_DRAW, -1, 2047, 1024, -5);          pace();
        // forget, then restart from the very same pen point
        offer(CMD_FORGET, 2047, -2048, -1, 1365);     pace();
        offer(CMD_DRAW, 1024, -5, 2047, -2048);       pace();
        offer(CMD_FORGET, -1, -1, -1, -1);            pace();
        offer(CMD_FORGET, 0, 0, 0, 0);                pace();
        offer(CMD_DRAW, 2047, -2048, 2047, -2048);    pace();
        offer(CMD_DRAW, 2047, -2048, -2048, 2047);    pace();
        // alternating bit patterns on several fields
        offer(CMD_DRAW, -2048, 2047, 1365, -1366);    pace();
        offer(CMD_DRAW, 1365, 1365, 682, 682);        pace();
        offer(CMD_DRAW, 682, 682, -1, -1);            pace();
        offer(CMD_FORGET, -1366, 1365, -1366, 1365);  pace();
        offer(CMD_DRAW, -1, -1, 1023, 0);             pace();
        // low y unchanged while high x moves
        offer(CMD_DRAW, 1023, 0, 5, 0);               pace();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            offer_random();
            pace();
        end

        seg_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        // let any stray trailing byte show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (seg_valid && seg_ready)
            segs_taken <= segs_taken + 1;
    end

    // ------------------------------------------------------------------------
    // receiver: changing stall pattern, plus one long hold-off so the segment
    // queue fills and the input stalls while beats are still on offer
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && segs_taken >= HOLD_AFTER)
            begin
                byte_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(3, 0));
                    mode_left = $urandom_range(80, 16);
                end
                mode_left--;
                rx_tick++;
                case (rx_mode)
                    RX_STEADY: byte_ready <= 1'b1;
                    RX_COIN:   byte_ready <= 1'($urandom_range(1, 0));
                    RX_SPARSE: byte_ready <= (rx_tick % 4 == 0);
                    default:   byte_ready <= ($urandom_range(9, 0) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in a row with no beat on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((seg_valid && seg_ready) || (byte_valid && byte_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
